// ----- sv/dlp_pkg.sv -----
package dlp_pkg;

  localparam int MaxNodes  = 1024;
  localparam int MaxEdges  = 4096;
  localparam int VtxW      = $clog2(MaxNodes);       // stored vertex index
  localparam int VcntW     = VtxW + 1;               // vertex count / loop index
  localparam int EidxW     = $clog2(MaxEdges);
  localparam int EcntW     = EidxW + 1;
  localparam int DegW      = 13;
  localparam int LenW      = 10;
  localparam int CfgW      = 11;

  typedef struct packed {
    logic            set;
    logic [LenW-1:0] len;
    logic [DegW-1:0] indeg;
  } node_t;

  typedef struct packed {
    logic [VtxW-1:0] src;
    logic [VtxW-1:0] tgt;
  } edge_t;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_CNT_RD = 4'd2;
  localparam logic [3:0] S_CNT_NR = 4'd3;
  localparam logic [3:0] S_CNT_WR = 4'd4;
  localparam logic [3:0] S_SEED_R = 4'd5;
  localparam logic [3:0] S_SEED_W = 4'd6;
  localparam logic [3:0] S_POP_Q  = 4'd7;
  localparam logic [3:0] S_POP_U  = 4'd8;
  localparam logic [3:0] S_POP_L  = 4'd9;
  localparam logic [3:0] S_REL_RD = 4'd10;
  localparam logic [3:0] S_REL_NR = 4'd11;
  localparam logic [3:0] S_REL_WR = 4'd12;
  localparam logic [3:0] S_MAX_RD = 4'd13;
  localparam logic [3:0] S_MAX_CK = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

endpackage

// ----- sv/dag_longest_path_dp.sv -----
// Longest path in a directed graph by Kahn's topological order.
//
// Input channel (in_valid/in_stall): one beat per directed edge, edge_from ->
// edge_to, vertices numbered from 1. has_edge = 0 makes a beat carry no edge;
// last_item = 1 closes the graph load and starts the traversal. Edges naming
// vertex 0 or one above min(node_count,1024), and edges beyond 4096, drop. Output
// channel (out_valid/out_stall): one beat, longest_path, per graph. The user must
// write node_count (node_count_we/node_count_wdata) only while idle; unenforced.
//
// Throughput: while loading, one edge beat per cycle. After the last beat the
// input stalls while the traversal runs against the edge, node and queue
// memories (one read port each, registered reads): clear the node records,
// recount in-degrees, seed the queue with the zero in-degree vertices, scan the
// edge list for each popped vertex to relax its out-edges, then take the maximum over
// n = min(node_count,1024) vertices. The edge scan per popped vertex dominates.
// The result register parts the two channels; if the receiver stalls, the
// next result waits in the final state until the register frees.
// Reset (synchronous, rst high): node_count returns to 1, edge count to 0,
// no result pending. Node entries are cleared by the pass at traversal start.
module dag_longest_path_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       node_count_we,
  input  logic [dlp_pkg::CfgW-1:0]   node_count_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dlp_pkg::CfgW-1:0]   edge_from,
  input  logic [dlp_pkg::CfgW-1:0]   edge_to,
  input  logic                       has_edge,
  input  logic                       last_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dlp_pkg::LenW-1:0]   longest_path
);
  import dlp_pkg::*;

  // Memories: edge list, per-vertex node record, ready queue.
  edge_t mem_edge [MaxEdges];
  node_t mem_node [MaxNodes];
  logic [VtxW-1:0] mem_q [MaxNodes];

  edge_t           edge_rd;
  node_t           node_rd;
  logic [VtxW-1:0] q_rd;

  logic [3:0]       state;
  logic [CfgW-1:0]  node_count;
  logic [VcntW-1:0] nl;          // vertex limit latched for the traversal
  logic [EcntW-1:0] edge_total;
  logic [EcntW-1:0] ei;          // edge scan index
  logic [VcntW-1:0] vi;          // vertex scan index
  logic [VcntW-1:0] head, tail;
  logic [VtxW-1:0]  u, v;
  logic [LenW-1:0]  ulen, best;

  // Ports of the memories, driven by the sequencer below.
  logic             e_we, e_re, n_we, n_re, q_we, q_re;
  logic [EidxW-1:0] e_waddr, e_raddr;
  edge_t            e_wdata;
  logic [VtxW-1:0]  n_waddr, n_raddr, q_waddr, q_raddr, q_wdata;
  node_t            n_wdata;

  logic [VcntW-1:0] n_cur;
  logic             from_ok, to_ok, in_acc, out_free;
  logic [LenW-1:0]  cand;
  logic [DegW-1:0]  deg_dec;

  always_comb begin
    n_cur = (node_count > CfgW'(MaxNodes)) ? VcntW'(MaxNodes) : node_count[VcntW-1:0];
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign from_ok  = (edge_from != '0) && (edge_from <= CfgW'(n_cur));
  assign to_ok    = (edge_to != '0) && (edge_to <= CfgW'(n_cur));
  assign out_free = !out_valid || !out_stall;
  assign cand     = ulen + LenW'(1);
  assign deg_dec  = node_rd.indeg - DegW'(1);

  // Memory ports
  always_comb begin
    e_we    = in_acc && has_edge && from_ok && to_ok && (edge_total < EcntW'(MaxEdges));
    e_waddr = edge_total[EidxW-1:0];
    e_wdata = '{src: VtxW'(edge_from - CfgW'(1)), tgt: VtxW'(edge_to - CfgW'(1))};
    e_re    = (state == S_CNT_RD || state == S_REL_RD) && (ei != edge_total);
    e_raddr = ei[EidxW-1:0];

    n_we    = 1'b0;
    n_waddr = v;
    n_wdata = node_rd;
    n_re    = 1'b0;
    n_raddr = edge_rd.tgt;
    q_we    = 1'b0;
    q_waddr = tail[VtxW-1:0];
    q_wdata = v;
    q_re    = (state == S_POP_Q) && (head != tail);
    q_raddr = head[VtxW-1:0];

    unique case (state)
      S_CLR: begin
        n_we    = (vi != nl);
        n_waddr = vi[VtxW-1:0];
        n_wdata = '0;
      end
      S_CNT_NR: begin
        n_re = ({1'b0, edge_rd.src} < nl) && ({1'b0, edge_rd.tgt} < nl);
      end
      S_CNT_WR: begin
        n_we          = 1'b1;
        n_wdata.indeg = node_rd.indeg + DegW'(1);
      end
      S_SEED_R: begin
        n_re    = (vi != nl);
        n_raddr = vi[VtxW-1:0];
      end
      S_SEED_W: begin
        n_waddr = v;
        if (node_rd.indeg == '0) begin
          n_we    = 1'b1;
          n_wdata = '{set: 1'b1, len: '0, indeg: '0};
          q_we    = !tail[VcntW-1];
        end
      end
      S_POP_U: begin
        n_re    = 1'b1;
        n_raddr = q_rd;
      end
      S_REL_NR: begin
        n_re = (edge_rd.src == u) && ({1'b0, edge_rd.tgt} < nl);
      end
      S_REL_WR: begin
        n_we = 1'b1;
        if (!node_rd.set || cand > node_rd.len) begin
          n_wdata.set = 1'b1;
          n_wdata.len = cand;
        end
        if (node_rd.indeg != '0) begin
          n_wdata.indeg = deg_dec;
          q_we          = (deg_dec == '0) && !tail[VcntW-1];
        end
      end
      S_MAX_RD: begin
        n_re    = (vi != nl);
        n_raddr = vi[VtxW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) mem_edge[e_waddr] <= e_wdata;
    if (e_re) edge_rd <= mem_edge[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) mem_node[n_waddr] <= n_wdata;
    if (n_re) node_rd <= mem_node[n_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) mem_q[q_waddr] <= q_wdata;
    if (q_re) q_rd <= mem_q[q_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= CfgW'(1);
      edge_total <= '0;
      out_valid  <= 1'b0;
      nl <= '0; ei <= '0; vi <= '0; head <= '0; tail <= '0;
    end else begin
      if (node_count_we) node_count <= node_count_wdata;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (e_we) edge_total <= edge_total + EcntW'(1);

      unique case (state)
        S_IDLE: begin
          if (in_acc && last_item) begin
            nl    <= n_cur;
            vi    <= '0;
            state <= S_CLR;
          end
        end
        S_CLR: begin
          // wipe in-degree and length of every vertex in use
          if (vi == nl) begin
            ei    <= '0;
            state <= S_CNT_RD;
          end else begin
            vi <= vi + VcntW'(1);
          end
        end
        S_CNT_RD: begin
          if (ei == edge_total) begin
            vi    <= '0;
            tail  <= '0;
            state <= S_SEED_R;
          end else begin
            state <= S_CNT_NR;
          end
        end
        S_CNT_NR: begin
          ei    <= ei + EcntW'(1);
          v     <= edge_rd.tgt;
          state <= n_re ? S_CNT_WR : S_CNT_RD;
        end
        S_CNT_WR: state <= S_CNT_RD;
        S_SEED_R: begin
          if (vi == nl) begin
            head  <= '0;
            state <= S_POP_Q;
          end else begin
            v     <= vi[VtxW-1:0];
            state <= S_SEED_W;
          end
        end
        S_SEED_W: begin
          if (q_we) tail <= tail + VcntW'(1);
          vi    <= vi + VcntW'(1);
          state <= S_SEED_R;
        end
        S_POP_Q: begin
          if (head == tail) begin
            vi    <= '0;
            best  <= '0;
            state <= S_MAX_RD;
          end else begin
            head  <= head + VcntW'(1);
            state <= S_POP_U;
          end
        end
        S_POP_U: begin
          u     <= q_rd;
          state <= S_POP_L;
        end
        S_POP_L: begin
          ulen  <= node_rd.len;
          ei    <= '0;
          state <= S_REL_RD;
        end
        S_REL_RD: state <= (ei == edge_total) ? S_POP_Q : S_REL_NR;
        S_REL_NR: begin
          ei    <= ei + EcntW'(1);
          v     <= edge_rd.tgt;
          state <= n_re ? S_REL_WR : S_REL_RD;
        end
        S_REL_WR: begin
          if (q_we) tail <= tail + VcntW'(1);
          state <= S_REL_RD;
        end
        S_MAX_RD: state <= (vi == nl) ? S_DONE : S_MAX_CK;
        S_MAX_CK: begin
          if (node_rd.set && node_rd.len > best) best <= node_rd.len;
          vi    <= vi + VcntW'(1);
          state <= S_MAX_RD;
        end
        S_DONE: begin
          // hold until the result register frees, then drop the graph
          if (out_free) begin
            out_valid    <= 1'b1;
            longest_path <= best;
            edge_total   <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= VcntW'(MaxNodes)) else $error("queue tail past capacity");
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_Q) |-> head <= tail) else $error("queue head past tail");
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_total <= EcntW'(MaxEdges)) else $error("edge count past capacity");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result without traversal");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    e_we |-> state == S_IDLE) else $error("edge write outside load");
`endif

endmodule

// ----- test/tb_dag_longest_path_dp.sv -----
module tb_dag_longest_path_dp;
  timeunit 1ns;
  timeprecision 1ps;

  import dlp_pkg::*;

  localparam int IdleLimit = 400000;

  // one input beat as the driver presents it
  typedef struct {
    logic [CfgW-1:0] from_v;
    logic [CfgW-1:0] to_v;
    logic            has_e;
    logic            last_e;
  } edge_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic node_count_we = 1'b0;
  logic [CfgW-1:0] node_count_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CfgW-1:0] edge_from = '0;
  logic [CfgW-1:0] edge_to = '0;
  logic has_edge = 1'b0;
  logic last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LenW-1:0] longest_path;

  dag_longest_path_dp uut (
    .clk(clk), .rst(rst),
    .node_count_we(node_count_we), .node_count_wdata(node_count_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .edge_from(edge_from), .edge_to(edge_to),
    .has_edge(has_edge), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .longest_path(longest_path)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: the graph as loaded so far
  int unsigned pred_nodes = 1;
  int unsigned pred_src[$];
  int unsigned pred_tgt[$];

  edge_beat_t      pending_beats[$];
  logic [LenW-1:0] expected_lengths[$];
  int              mismatch_count = 0;
  int              idle_cycles = 0;
  bit              hold_receiver = 1'b0;

  // Kahn's order over the loaded edges, longest distance in edges
  function automatic logic [LenW-1:0] longest_from_sources();
    int unsigned n, head, res;
    int unsigned indeg[MaxNodes];
    int unsigned path_len[MaxNodes];
    bit          got[MaxNodes];
    int unsigned order[$];
    n = (pred_nodes > MaxNodes) ? MaxNodes : pred_nodes;
    head = 0;
    res = 0;
    for (int i = 0; i < MaxNodes; i++) begin
      indeg[i] = 0;
      path_len[i] = 0;
      got[i] = 1'b0;
    end
    foreach (pred_src[e])
      if (pred_src[e] < n && pred_tgt[e] < n) indeg[pred_tgt[e]]++;
    for (int unsigned i = 0; i < n; i++)
      if (indeg[i] == 0) begin
        order = {order, i};
        got[i] = 1'b1;
      end
    while (head < order.size()) begin
      int unsigned u;
      u = order[head];
      head++;
      foreach (pred_src[e]) begin
        int unsigned v;
        v = pred_tgt[e];
        if (pred_src[e] == u && v < n) begin
          if (!got[v] || path_len[u] + 1 > path_len[v]) begin
            path_len[v] = path_len[u] + 1;
            got[v] = 1'b1;
          end
          if (indeg[v] > 0) begin
            indeg[v]--;
            if (indeg[v] == 0) order = {order, v};
          end
        end
      end
    end
    for (int unsigned i = 0; i < n; i++)
      if (got[i] && path_len[i] > res) res = path_len[i];
    return res[LenW-1:0];
  endfunction

  // fold one accepted beat into the predictor
  task automatic absorb_beat(input edge_beat_t b);
    int unsigned n;
    n = (pred_nodes > MaxNodes) ? MaxNodes : pred_nodes;
    if (b.has_e && b.from_v >= 1 && b.from_v <= n && b.to_v >= 1 && b.to_v <= n &&
        pred_src.size() < MaxEdges) begin
      pred_src = {pred_src, int'(b.from_v) - 1};
      pred_tgt = {pred_tgt, int'(b.to_v) - 1};
    end
    if (b.last_e) begin
      expected_lengths = {expected_lengths, longest_from_sources()};
      pred_src.delete();
      pred_tgt.delete();
    end
  endtask

  // driver: present beats at the falling edge, advance on acceptance
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      absorb_beat(pending_beats.pop_front());
      send_gap <= $urandom_range(0, 10);
    end else if (send_gap > 0 && !in_valid) begin
      send_gap <= send_gap - 1;
    end
  end

  always @(negedge clk) begin
    if (rst || send_gap > 0 || pending_beats.size() == 0) begin
      in_valid <= 1'b0;
    end else begin
      in_valid  <= 1'b1;
      edge_from <= pending_beats[0].from_v;
      edge_to   <= pending_beats[0].to_v;
      has_edge  <= pending_beats[0].has_e;
      last_item <= pending_beats[0].last_e;
    end
  end

  // monitor: check each accepted result against the oldest expectation
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_lengths.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result longest_path=%0d", longest_path);
      end else begin
        logic [LenW-1:0] want;
        want = expected_lengths.pop_front();
        if (want !== longest_path) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("longest_path mismatch: expected %0d actual %0d", want, longest_path);
        end
      end
      recv_gap <= $urandom_range(0, 10);
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
    end
  end

  always @(negedge clk)
    out_stall <= rst || hold_receiver || recv_gap > 0;

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_beat(input int f, input int t, input bit he, input bit li);
    edge_beat_t b;
    b.from_v = f[CfgW-1:0];
    b.to_v = t[CfgW-1:0];
    b.has_e = he;
    b.last_e = li;
    pending_beats = {pending_beats, b};
  endtask

  // well-formed graph: mostly forward edges, a few back edges and noise
  task automatic queue_graph(input int nv, input int ne);
    for (int k = 0; k < ne; k++) begin
      int a, c, r;
      r = $urandom_range(0, 19);
      a = $urandom_range(1, nv);
      c = $urandom_range(1, nv);
      if (r == 0) queue_beat($urandom, $urandom, 1'b1, 1'b0);
      else if (r == 1) queue_beat($urandom, $urandom, 1'b0, 1'b0);
      else if (r < 4 || a == c) queue_beat(a, c, 1'b1, 1'b0);
      else if (a < c) queue_beat(a, c, 1'b1, 1'b0);
      else queue_beat(c, a, 1'b1, 1'b0);
    end
    if ($urandom_range(0, 1)) queue_beat($urandom_range(1, nv), $urandom_range(1, nv), 1'b1, 1'b1);
    else queue_beat($urandom, $urandom, 1'b0, 1'b1);
  endtask

  // wait for the block to drain, then settle before a register write
  task automatic drain();
    while (pending_beats.size() != 0 || expected_lengths.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_nodes(input int n);
    @(negedge clk);
    node_count_we <= 1'b1;
    node_count_wdata <= n[CfgW-1:0];
    @(negedge clk);
    node_count_we <= 1'b0;
    pred_nodes = n;
  endtask

  initial begin
    int sizes[6];
    sizes = '{1, 5, 12, 2047, 30, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of one vertex: a self edge and an empty end
    queue_beat(1, 1, 1'b1, 1'b1);
    queue_beat(0, 0, 1'b0, 1'b1);
    drain();
    set_nodes(1024);
    // chain through the top vertices, out-of-range names dropped
    queue_beat(1, 1024, 1'b1, 1'b0);
    queue_beat(1024, 2, 1'b1, 1'b0);
    queue_beat(0, 3, 1'b1, 1'b0);
    queue_beat(2047, 3, 1'b1, 1'b0);
    queue_beat(2, 1025, 1'b1, 1'b0);
    queue_beat(5, 6, 1'b0, 1'b0);
    queue_beat(2, 3, 1'b1, 1'b1);
    drain();
    set_nodes(4);
    // a cycle blocks its vertices; the edge on the last beat is loaded as well
    queue_beat(1, 2, 1'b1, 1'b0);
    queue_beat(2, 3, 1'b1, 1'b0);
    queue_beat(3, 2, 1'b1, 1'b0);
    queue_beat(3, 4, 1'b1, 1'b1);
    queue_beat(1, 2, 1'b1, 1'b0);
    queue_beat(2, 3, 1'b1, 1'b0);
    queue_beat(3, 4, 1'b1, 1'b1);
    // long receiver hold-off while the sender keeps offering graphs
    hold_receiver = 1'b1;
    for (int g = 0; g < 4; g++) queue_graph(4, 5);
    repeat (600) @(posedge clk);
    hold_receiver = 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      set_nodes(sizes[p]);
      for (int g = 0; g < 9; g++)
        queue_graph((sizes[p] > 16 || sizes[p] == 0) ? 16 : sizes[p], $urandom_range(1, 12));
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_lengths.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- dag_longest_path_dp.f -----
sv/dlp_pkg.sv
sv/dag_longest_path_dp.sv
test/tb_dag_longest_path_dp.sv
